### rtl/tbb_pkg.sv
// ----------------------------------------------------------------------------
// tbb_pkg - shared types and constants of the transformed box bounds block
// Coordinate and payload types, register indexes and control groups that
// travel between the product stage, the vertex lanes and the merge stage.
// ----------------------------------------------------------------------------
package tbb_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int COEF_WIDTH  = 20;
  localparam int FRAC_BITS   = 16;

  localparam int NUM_AXES    = 3;
  localparam int NUM_CORNERS = 1 << NUM_AXES;
  localparam int PIPE_DEPTH  = 4;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int PERM_W      = 7;
  localparam int PERM_EN_BIT = 6;
  localparam int DIM_W       = 2;

  localparam logic [DIM_W-1:0] BOX_DIM_2D    = 2'd2;
  localparam logic [DIM_W-1:0] OUT_DIM_XY    = 2'd2;
  localparam logic [DIM_W-1:0] OUT_DIM_ALL   = 2'd3;
  localparam logic [1:0]       PERM_SRC_NONE = 2'd3;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    coord_t low_x;
    coord_t low_y;
    coord_t low_z;
    coord_t high_x;
    coord_t high_y;
    coord_t high_z;
  } box_t;

  typedef struct packed {
    coord_t out_low_x;
    coord_t out_low_y;
    coord_t out_low_z;
    coord_t out_high_x;
    coord_t out_high_y;
    coord_t out_high_z;
  } bounds_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MATRIX_ROW0 = 3'd0,
    CFG_MATRIX_ROW1 = 3'd1,
    CFG_MATRIX_ROW2 = 3'd2,
    CFG_PERM_MODE   = 3'd3,
    CFG_BOX_DIM     = 3'd4,
    CFG_OUT_DIM     = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic                      perm_en;
    logic [NUM_AXES-1:0][1:0]  src;
  } lane_ctrl_t;

  typedef struct packed {
    logic keep_y;
    logic keep_z;
  } proj_ctrl_t;

endpackage

### rtl/tbb_prod.sv
// ----------------------------------------------------------------------------
// tbb_prod - coefficient by coordinate products
// Forms every matrix coefficient times the low and the high coordinate of
// its column, one registered multiplier per product, and registers the
// corner coordinates for the lanes.
// ----------------------------------------------------------------------------
module tbb_prod #(
  parameter int  COEF_WIDTH = tbb_pkg::COEF_WIDTH,
  localparam int PROD_W     = tbb_pkg::COORD_WIDTH + COEF_WIDTH,
  localparam int MAT_W      = tbb_pkg::NUM_AXES * COEF_WIDTH
) (
  input  logic                     clk_i,
  input  tbb_pkg::box_t            box_i,
  input  logic                     dim3_i,
  input  logic [MAT_W-1:0]         row_i     [tbb_pkg::NUM_AXES],
  output logic signed [PROD_W-1:0] prod_lo_o [tbb_pkg::NUM_AXES][tbb_pkg::NUM_AXES],
  output logic signed [PROD_W-1:0] prod_hi_o [tbb_pkg::NUM_AXES][tbb_pkg::NUM_AXES],
  output tbb_pkg::coord_t          lo_o      [tbb_pkg::NUM_AXES],
  output tbb_pkg::coord_t          hi_o      [tbb_pkg::NUM_AXES]
);

  tbb_pkg::coord_t               lo_c   [tbb_pkg::NUM_AXES];
  tbb_pkg::coord_t               hi_c   [tbb_pkg::NUM_AXES];
  logic signed [COEF_WIDTH-1:0]  coef_c [tbb_pkg::NUM_AXES][tbb_pkg::NUM_AXES];

  logic signed [PROD_W-1:0] prod_lo_q [tbb_pkg::NUM_AXES][tbb_pkg::NUM_AXES];
  logic signed [PROD_W-1:0] prod_hi_q [tbb_pkg::NUM_AXES][tbb_pkg::NUM_AXES];
  tbb_pkg::coord_t          lo_q      [tbb_pkg::NUM_AXES];
  tbb_pkg::coord_t          hi_q      [tbb_pkg::NUM_AXES];

  always_comb begin
    lo_c[0] = box_i.low_x;
    lo_c[1] = box_i.low_y;
    hi_c[0] = box_i.high_x;
    hi_c[1] = box_i.high_y;
    // a 2d box sits in the z = 0 plane
    lo_c[2] = dim3_i ? box_i.low_z  : '0;
    hi_c[2] = dim3_i ? box_i.high_z : '0;
    for (int a = 0; a < tbb_pkg::NUM_AXES; a++) begin
      for (int k = 0; k < tbb_pkg::NUM_AXES; k++) begin
        coef_c[a][k] = $signed(row_i[a][k*COEF_WIDTH +: COEF_WIDTH]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < tbb_pkg::NUM_AXES; a++) begin
      for (int k = 0; k < tbb_pkg::NUM_AXES; k++) begin
        prod_lo_q[a][k] <= PROD_W'(coef_c[a][k]) * PROD_W'(lo_c[k]);
        prod_hi_q[a][k] <= PROD_W'(coef_c[a][k]) * PROD_W'(hi_c[k]);
      end
      lo_q[a] <= lo_c[a];
      hi_q[a] <= hi_c[a];
    end
  end

  assign prod_lo_o = prod_lo_q;
  assign prod_hi_o = prod_hi_q;
  assign lo_o      = lo_q;
  assign hi_o      = hi_q;

endmodule

### rtl/tbb_lane.sv
// ----------------------------------------------------------------------------
// tbb_lane - one corner vertex of the box
// Sums the products picked by this corner, rounds and saturates each axis,
// or picks the permuted source coordinate, and registers the mapped vertex.
// ----------------------------------------------------------------------------
module tbb_lane #(
  parameter int  COEF_WIDTH = tbb_pkg::COEF_WIDTH,
  parameter int  FRAC_BITS  = tbb_pkg::FRAC_BITS,
  parameter int  CORNER     = 0,
  localparam int PROD_W     = tbb_pkg::COORD_WIDTH + COEF_WIDTH,
  localparam int SUM_W      = PROD_W + 2
) (
  input  logic                     clk_i,
  input  logic signed [PROD_W-1:0] prod_lo_i [tbb_pkg::NUM_AXES][tbb_pkg::NUM_AXES],
  input  logic signed [PROD_W-1:0] prod_hi_i [tbb_pkg::NUM_AXES][tbb_pkg::NUM_AXES],
  input  tbb_pkg::coord_t          lo_i      [tbb_pkg::NUM_AXES],
  input  tbb_pkg::coord_t          hi_i      [tbb_pkg::NUM_AXES],
  input  tbb_pkg::lane_ctrl_t      ctrl_i,
  output tbb_pkg::coord_t          val_o     [tbb_pkg::NUM_AXES]
);

  localparam int CW = tbb_pkg::COORD_WIDTH;
  localparam logic [tbb_pkg::NUM_AXES-1:0] CORNER_BITS = CORNER[tbb_pkg::NUM_AXES-1:0];
  localparam logic signed [SUM_W-1:0] HALF =
    {{(SUM_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
  localparam logic signed [SUM_W-1:0] SAT_MAX = {{(SUM_W-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_MIN = {{(SUM_W-CW+1){1'b1}}, {(CW-1){1'b0}}};
  localparam tbb_pkg::coord_t COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam tbb_pkg::coord_t COORD_MIN = {1'b1, {(CW-1){1'b0}}};

  logic signed [SUM_W-1:0] sum_c  [tbb_pkg::NUM_AXES];
  logic signed [SUM_W-1:0] rnd_c  [tbb_pkg::NUM_AXES];
  tbb_pkg::coord_t         mat_c  [tbb_pkg::NUM_AXES];
  tbb_pkg::coord_t         perm_c [tbb_pkg::NUM_AXES];
  tbb_pkg::coord_t         val_d  [tbb_pkg::NUM_AXES];
  tbb_pkg::coord_t         val_q  [tbb_pkg::NUM_AXES];

  always_comb begin
    for (int a = 0; a < tbb_pkg::NUM_AXES; a++) begin
      sum_c[a] = '0;
      for (int k = 0; k < tbb_pkg::NUM_AXES; k++) begin
        sum_c[a] = sum_c[a] +
                   SUM_W'(CORNER_BITS[k] ? prod_hi_i[a][k] : prod_lo_i[a][k]);
      end
      // round half up, then saturate to the coordinate range
      rnd_c[a] = (sum_c[a] + HALF) >>> FRAC_BITS;
      if (rnd_c[a] > SAT_MAX) begin
        mat_c[a] = COORD_MAX;
      end else if (rnd_c[a] < SAT_MIN) begin
        mat_c[a] = COORD_MIN;
      end else begin
        mat_c[a] = rnd_c[a][CW-1:0];
      end
      if (ctrl_i.src[a] == tbb_pkg::PERM_SRC_NONE) begin
        perm_c[a] = '0;
      end else if (CORNER_BITS[ctrl_i.src[a]]) begin
        perm_c[a] = hi_i[ctrl_i.src[a]];
      end else begin
        perm_c[a] = lo_i[ctrl_i.src[a]];
      end
      val_d[a] = ctrl_i.perm_en ? perm_c[a] : mat_c[a];
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

### rtl/tbb_merge.sv
// ----------------------------------------------------------------------------
// tbb_merge - minimum and maximum over the corner lanes
// Two registered levels: each half of the lanes is reduced first, then the
// two halves, and axes that are projected away are forced to zero.
// ----------------------------------------------------------------------------
module tbb_merge (
  input  logic                clk_i,
  input  tbb_pkg::coord_t     lane_i [tbb_pkg::NUM_CORNERS][tbb_pkg::NUM_AXES],
  input  tbb_pkg::proj_ctrl_t proj_i,
  output tbb_pkg::bounds_t    result_o
);

  localparam int GROUP = tbb_pkg::NUM_CORNERS / 2;

  tbb_pkg::coord_t  mn_a_d [2][tbb_pkg::NUM_AXES];
  tbb_pkg::coord_t  mx_a_d [2][tbb_pkg::NUM_AXES];
  tbb_pkg::coord_t  mn_a_q [2][tbb_pkg::NUM_AXES];
  tbb_pkg::coord_t  mx_a_q [2][tbb_pkg::NUM_AXES];
  tbb_pkg::coord_t  mn_c   [tbb_pkg::NUM_AXES];
  tbb_pkg::coord_t  mx_c   [tbb_pkg::NUM_AXES];
  tbb_pkg::bounds_t result_d;
  tbb_pkg::bounds_t result_q;

  always_comb begin
    for (int h = 0; h < 2; h++) begin
      for (int a = 0; a < tbb_pkg::NUM_AXES; a++) begin
        mn_a_d[h][a] = lane_i[h*GROUP][a];
        mx_a_d[h][a] = lane_i[h*GROUP][a];
        for (int j = 1; j < GROUP; j++) begin
          if (lane_i[h*GROUP+j][a] < mn_a_d[h][a]) begin
            mn_a_d[h][a] = lane_i[h*GROUP+j][a];
          end
          if (lane_i[h*GROUP+j][a] > mx_a_d[h][a]) begin
            mx_a_d[h][a] = lane_i[h*GROUP+j][a];
          end
        end
      end
    end
  end

  always_comb begin
    for (int a = 0; a < tbb_pkg::NUM_AXES; a++) begin
      mn_c[a] = (mn_a_q[1][a] < mn_a_q[0][a]) ? mn_a_q[1][a] : mn_a_q[0][a];
      mx_c[a] = (mx_a_q[1][a] > mx_a_q[0][a]) ? mx_a_q[1][a] : mx_a_q[0][a];
    end
    result_d.out_low_x  = mn_c[0];
    result_d.out_high_x = mx_c[0];
    result_d.out_low_y  = proj_i.keep_y ? mn_c[1] : '0;
    result_d.out_high_y = proj_i.keep_y ? mx_c[1] : '0;
    result_d.out_low_z  = proj_i.keep_z ? mn_c[2] : '0;
    result_d.out_high_z = proj_i.keep_z ? mx_c[2] : '0;
  end

  always_ff @(posedge clk_i) begin
    mn_a_q   <= mn_a_d;
    mx_a_q   <= mx_a_d;
    result_q <= result_d;
  end

  assign result_o = result_q;

endmodule

### rtl/transformed_box_bounds.sv
// ----------------------------------------------------------------------------
// transformed_box_bounds - bounds of a mapped axis-aligned box
// Maps the corners of a 2d or 3d box by a permutation or a 3x3 fixed-point
// matrix and returns the bounding box of the result, projected to 1-3 axes.
// ----------------------------------------------------------------------------
// usage:
//   a box transaction is taken on a rising edge with start_i high and busy_o
//   low; the result shows on result_o for exactly one cycle with
//   result_valid_o high, after the box has passed the product stage, the lanes and both merge levels
//   throughput is one box per cycle while busy_o is low: the product stage, the eight corner
//   lanes and the two merge levels each hold a different box
//   the result side has no back pressure, so nothing ever waits; results
//   leave in the order the boxes came in
//   configuration goes over the cfg_* write channel (always ready) and is
//   meant to change only while no box is in flight
//   reset clears the pipeline, loads the identity matrix, 3d box, 3d output
//   and holds busy_o high until the first clock edge after reset is released
// ----------------------------------------------------------------------------
module transformed_box_bounds #(
  parameter int COEF_WIDTH = tbb_pkg::COEF_WIDTH,
  parameter int FRAC_BITS  = tbb_pkg::FRAC_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  tbb_pkg::box_t                  box_i,
  output logic                           busy_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tbb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tbb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                           result_valid_o,
  output tbb_pkg::bounds_t               result_o
);

  localparam int MAT_W  = tbb_pkg::NUM_AXES * COEF_WIDTH;
  localparam int PROD_W = tbb_pkg::COORD_WIDTH + COEF_WIDTH;
  localparam int PD     = tbb_pkg::PIPE_DEPTH;
  localparam logic [MAT_W-1:0] ONE_BIT  = {{(MAT_W-1){1'b0}}, 1'b1};
  localparam logic [MAT_W-1:0] ROW0_RST = ONE_BIT << FRAC_BITS;
  localparam logic [MAT_W-1:0] ROW1_RST = ONE_BIT << (FRAC_BITS + COEF_WIDTH);
  localparam logic [MAT_W-1:0] ROW2_RST = ONE_BIT << (FRAC_BITS + 2 * COEF_WIDTH);

  logic [MAT_W-1:0]                 row_q [tbb_pkg::NUM_AXES];
  logic [tbb_pkg::PERM_W-1:0]       perm_q;
  logic [tbb_pkg::DIM_W-1:0]        box_dim_q;
  logic [tbb_pkg::DIM_W-1:0]        out_dim_q;
  logic                             busy_q;
  logic [PD-1:0]                    pipe_valid_q;

  logic                             in_accept;
  logic                             dim3;
  tbb_pkg::lane_ctrl_t              lane_ctrl;
  tbb_pkg::proj_ctrl_t              proj_ctrl;

  logic signed [PROD_W-1:0] prod_lo [tbb_pkg::NUM_AXES][tbb_pkg::NUM_AXES];
  logic signed [PROD_W-1:0] prod_hi [tbb_pkg::NUM_AXES][tbb_pkg::NUM_AXES];
  tbb_pkg::coord_t          corner_lo [tbb_pkg::NUM_AXES];
  tbb_pkg::coord_t          corner_hi [tbb_pkg::NUM_AXES];
  tbb_pkg::coord_t          lane_val  [tbb_pkg::NUM_CORNERS][tbb_pkg::NUM_AXES];

  assign in_accept   = start_i && !busy_q;
  assign busy_o      = busy_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[0]     <= ROW0_RST;
      row_q[1]     <= ROW1_RST;
      row_q[2]     <= ROW2_RST;
      perm_q       <= '0;
      box_dim_q    <= tbb_pkg::OUT_DIM_ALL;
      out_dim_q    <= tbb_pkg::OUT_DIM_ALL;
      busy_q       <= 1'b1;
      pipe_valid_q <= '0;
    end else begin
      busy_q       <= 1'b0;
      pipe_valid_q <= {pipe_valid_q[PD-2:0], in_accept};
      if (cfg_valid_i) begin
        case (tbb_pkg::cfg_reg_e'(cfg_index_i))
          tbb_pkg::CFG_MATRIX_ROW0: row_q[0]  <= cfg_data_i[MAT_W-1:0];
          tbb_pkg::CFG_MATRIX_ROW1: row_q[1]  <= cfg_data_i[MAT_W-1:0];
          tbb_pkg::CFG_MATRIX_ROW2: row_q[2]  <= cfg_data_i[MAT_W-1:0];
          tbb_pkg::CFG_PERM_MODE:   perm_q    <= cfg_data_i[tbb_pkg::PERM_W-1:0];
          tbb_pkg::CFG_BOX_DIM:     box_dim_q <= cfg_data_i[tbb_pkg::DIM_W-1:0];
          tbb_pkg::CFG_OUT_DIM:     out_dim_q <= cfg_data_i[tbb_pkg::DIM_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // box dim code 2 is 2d, any other code is 3d; out dim 0 acts as 1
  always_comb begin
    dim3              = (box_dim_q != tbb_pkg::BOX_DIM_2D);
    lane_ctrl.perm_en = perm_q[tbb_pkg::PERM_EN_BIT];
    for (int a = 0; a < tbb_pkg::NUM_AXES; a++) begin
      lane_ctrl.src[a] = perm_q[2*a +: 2];
    end
    proj_ctrl.keep_y  = (out_dim_q == tbb_pkg::OUT_DIM_XY) ||
                        (out_dim_q == tbb_pkg::OUT_DIM_ALL);
    proj_ctrl.keep_z  = (out_dim_q == tbb_pkg::OUT_DIM_ALL) && dim3;
  end

  tbb_prod #(
    .COEF_WIDTH (COEF_WIDTH)
  ) u_prod (
    .clk_i     (clk_i),
    .box_i     (box_i),
    .dim3_i    (dim3),
    .row_i     (row_q),
    .prod_lo_o (prod_lo),
    .prod_hi_o (prod_hi),
    .lo_o      (corner_lo),
    .hi_o      (corner_hi)
  );

  for (genvar g = 0; g < tbb_pkg::NUM_CORNERS; g++) begin : g_lane
    tbb_lane #(
      .COEF_WIDTH (COEF_WIDTH),
      .FRAC_BITS  (FRAC_BITS),
      .CORNER     (g)
    ) u_lane (
      .clk_i     (clk_i),
      .prod_lo_i (prod_lo),
      .prod_hi_i (prod_hi),
      .lo_i      (corner_lo),
      .hi_i      (corner_hi),
      .ctrl_i    (lane_ctrl),
      .val_o     (lane_val[g])
    );
  end

  tbb_merge u_merge (
    .clk_i    (clk_i),
    .lane_i   (lane_val),
    .proj_i   (proj_ctrl),
    .result_o (result_o)
  );

  assign result_valid_o = pipe_valid_q[PD-1];

  // every accepted box yields its result after the full pipeline
  a_accept_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |-> ##4 result_valid_o)
    else $error("accepted box produced no result after pipeline latency");

  // once out of reset the block never refuses a box
  a_busy_stays_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |=> !busy_o)
    else $error("busy raised after reset");

  // bounds are ordered on every kept axis
  a_bounds_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_o.out_low_x <= result_o.out_high_x) &&
                       (result_o.out_low_y <= result_o.out_high_y) &&
                       (result_o.out_low_z <= result_o.out_high_z))
    else $error("low bound above high bound");

  // projected-away axes read as zero
  a_proj_y_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !$past(proj_ctrl.keep_y) |->
      (result_o.out_low_y == '0) && (result_o.out_high_y == '0))
    else $error("y bounds not zero while projected away");

  a_proj_z_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !$past(proj_ctrl.keep_z) |->
      (result_o.out_low_z == '0) && (result_o.out_high_z == '0))
    else $error("z bounds not zero while projected away");

endmodule
